@@ hw/rtl/rcpmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpmq_pkg: shared types and constants for the RC pulse mode qualifier
// Register indexes, channel codes, direction commands and the structs that
// pass between the control register file, the override counter and the
// direction run counter.
// ----------------------------------------------------------------------------
package rcpmq_pkg;

   localparam int PULSE_WIDTH_BITS = 16;
   localparam int CSR_BITS         = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int COUNT_BITS       = 4;
   localparam int RUN_BITS         = 6;
   // Compare width covers both the pulse field and the 16-bit thresholds
   localparam int CMP_BITS = (PULSE_WIDTH_BITS > CSR_BITS) ? PULSE_WIDTH_BITS : CSR_BITS;

   localparam logic [CMP_BITS-1:0] SPEED_MIN = CMP_BITS'(1000);
   localparam logic [CMP_BITS-1:0] SPEED_MAX = CMP_BITS'(2000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVR_ON_LOW       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVR_ON_HIGH      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVR_OFF_LOW      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVR_OFF_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVR_COUNT_TARGET = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIR_REV_BELOW    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIR_FWD_ABOVE    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIR_COUNT_LIMIT  = 3'd7;

   localparam logic CHAN_OVERRIDE = 1'b0;
   localparam logic CHAN_SPEED    = 1'b1;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_REV  = 2'd1,
      DIR_FWD  = 2'd2
   } dir_cmd_type;

   typedef struct packed {
      logic [CSR_BITS-1:0]   ovr_on_low;
      logic [CSR_BITS-1:0]   ovr_on_high;
      logic [CSR_BITS-1:0]   ovr_off_low;
      logic [CSR_BITS-1:0]   ovr_off_high;
      logic [COUNT_BITS-1:0] ovr_count_target;
      logic [CSR_BITS-1:0]   dir_rev_below;
      logic [CSR_BITS-1:0]   dir_fwd_above;
      logic [COUNT_BITS-1:0] dir_count_limit;
   } cfg_type;

   typedef struct packed {
      logic flag;
      logic arm_robot;
      logic arm_motor;
   } ovr_res_type;

endpackage

@@ hw/rtl/rcpmq_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpmq_csr: control register file
// Eight write-only threshold and count registers, loaded from the plain
// write port and presented to the datapath as one struct.
// ----------------------------------------------------------------------------
module rcpmq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [rcpmq_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rcpmq_pkg::CSR_BITS-1:0]        csr_wdata,
   output rcpmq_pkg::cfg_type                    cfg
);

   rcpmq_pkg::cfg_type cfg_ff;
   rcpmq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rcpmq_pkg::CSR_OVR_ON_LOW:       cfg_in.ovr_on_low   = csr_wdata;
            rcpmq_pkg::CSR_OVR_ON_HIGH:      cfg_in.ovr_on_high  = csr_wdata;
            rcpmq_pkg::CSR_OVR_OFF_LOW:      cfg_in.ovr_off_low  = csr_wdata;
            rcpmq_pkg::CSR_OVR_OFF_HIGH:     cfg_in.ovr_off_high = csr_wdata;
            rcpmq_pkg::CSR_OVR_COUNT_TARGET: begin
               cfg_in.ovr_count_target = csr_wdata[rcpmq_pkg::COUNT_BITS-1:0];
            end
            rcpmq_pkg::CSR_DIR_REV_BELOW:    cfg_in.dir_rev_below = csr_wdata;
            rcpmq_pkg::CSR_DIR_FWD_ABOVE:    cfg_in.dir_fwd_above = csr_wdata;
            rcpmq_pkg::CSR_DIR_COUNT_LIMIT:  begin
               cfg_in.dir_count_limit = csr_wdata[rcpmq_pkg::COUNT_BITS-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ovr_on_low       <= rcpmq_pkg::CSR_BITS'(1900);
         cfg_ff.ovr_on_high      <= rcpmq_pkg::CSR_BITS'(2010);
         cfg_ff.ovr_off_low      <= rcpmq_pkg::CSR_BITS'(900);
         cfg_ff.ovr_off_high     <= rcpmq_pkg::CSR_BITS'(1200);
         cfg_ff.ovr_count_target <= rcpmq_pkg::COUNT_BITS'(5);
         cfg_ff.dir_rev_below    <= rcpmq_pkg::CSR_BITS'(1200);
         cfg_ff.dir_fwd_above    <= rcpmq_pkg::CSR_BITS'(1800);
         cfg_ff.dir_count_limit  <= rcpmq_pkg::COUNT_BITS'(5);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/rcpmq_ovr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpmq_ovr: override qualifier
// Saturating up/down count of override-channel pulses in the on and off
// windows; sets the override flag at the target and clears it at zero.
// ----------------------------------------------------------------------------
module rcpmq_ovr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0]  pulse_width,
   input  rcpmq_pkg::cfg_type                      cfg,
   output logic                                    flag,
   output rcpmq_pkg::ovr_res_type                  res
);

   logic [rcpmq_pkg::COUNT_BITS-1:0] count_ff;
   logic [rcpmq_pkg::COUNT_BITS-1:0] count_in;
   logic                             flag_ff;
   logic                             flag_in;
   logic [rcpmq_pkg::CMP_BITS-1:0]   pulse_ext;
   logic [rcpmq_pkg::COUNT_BITS:0]   count_inc;
   logic                             on_win;
   logic                             off_win;

   always_comb begin
      pulse_ext = rcpmq_pkg::CMP_BITS'(pulse_width);
      on_win    = (pulse_ext > rcpmq_pkg::CMP_BITS'(cfg.ovr_on_low)) &&
                  (pulse_ext < rcpmq_pkg::CMP_BITS'(cfg.ovr_on_high));
      off_win   = (pulse_ext < rcpmq_pkg::CMP_BITS'(cfg.ovr_off_high)) &&
                  (pulse_ext > rcpmq_pkg::CMP_BITS'(cfg.ovr_off_low));
      count_inc = {1'b0, count_ff} + 1'b1;
      count_in  = count_ff;
      flag_in   = flag_ff;
      if (on_win) begin
         // clamp to target, also when the target was lowered below the count
         if (count_inc >= {1'b0, cfg.ovr_count_target}) begin
            count_in = cfg.ovr_count_target;
            flag_in  = 1'b1;
         end else begin
            count_in = count_inc[rcpmq_pkg::COUNT_BITS-1:0];
         end
      end else if (off_win) begin
         if (count_ff <= rcpmq_pkg::COUNT_BITS'(1)) begin
            count_in = '0;
            flag_in  = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   assign flag          = flag_ff;
   assign res.flag      = flag_in;
   assign res.arm_robot = flag_ff & ~flag_in;
   assign res.arm_motor = ~flag_ff & flag_in;

endmodule

@@ hw/rtl/rcpmq_dir.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpmq_dir: direction run counter
// Signed run of reverse or forward speed pulses; issues a direction command
// and clamps once the run passes the limit.
// ----------------------------------------------------------------------------
module rcpmq_dir (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0]  pulse_width,
   input  rcpmq_pkg::cfg_type                      cfg,
   output rcpmq_pkg::dir_cmd_type                  dir_cmd
);

   logic signed [rcpmq_pkg::RUN_BITS-1:0] run_ff;
   logic signed [rcpmq_pkg::RUN_BITS-1:0] run_in;
   logic signed [rcpmq_pkg::RUN_BITS-1:0] run_step;
   logic signed [rcpmq_pkg::RUN_BITS-1:0] lim;
   logic [rcpmq_pkg::CMP_BITS-1:0]        pulse_ext;

   always_comb begin
      pulse_ext = rcpmq_pkg::CMP_BITS'(pulse_width);
      lim       = signed'(rcpmq_pkg::RUN_BITS'(cfg.dir_count_limit));
      if (pulse_ext < rcpmq_pkg::CMP_BITS'(cfg.dir_rev_below)) begin
         run_step = run_ff - signed'(rcpmq_pkg::RUN_BITS'(1));
      end else if (pulse_ext > rcpmq_pkg::CMP_BITS'(cfg.dir_fwd_above)) begin
         run_step = run_ff + signed'(rcpmq_pkg::RUN_BITS'(1));
      end else begin
         run_step = '0;
      end
      run_in  = run_step;
      dir_cmd = rcpmq_pkg::DIR_NONE;
      if (run_step < -lim) begin
         run_in  = -lim;
         dir_cmd = rcpmq_pkg::DIR_REV;
      end else if (run_step > lim) begin
         run_in  = lim;
         dir_cmd = rcpmq_pkg::DIR_FWD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (step) begin
         run_ff <= run_in;
      end
   end

endmodule

@@ hw/rtl/rc_pulse_mode_qualifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_mode_qualifier_top: RC pulse mode qualifier
// Qualifies override and speed channel pulse widths into an override flag,
// arm events, forwarded motor pulses and direction commands.
// ----------------------------------------------------------------------------
// Takes one pulse beat per clock while results drain and returns one result
// beat per pulse: the pulse lands in an input register, the window compares
// and count updates run combinationally on it, and the result lands in an
// output register. Sustained throughput is one beat per cycle while rsp_ready
// stays high, as the override and direction counters update once per pulse.
// A stalled result holds the pipe; req_ready drops only when both registers
// are full and rsp_ready is low. Registers are written through csr_* and
// must change only while no pulse is in flight.
module rc_pulse_mode_qualifier_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_type,
   input  logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0]  req_pulse_width,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_override_active,
   output logic                                    rsp_arm_robot,
   output logic                                    rsp_arm_motor,
   output logic                                    rsp_motor_pulse_valid,
   output logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0]  rsp_motor_pulse,
   output logic [1:0]                              rsp_direction_cmd,
   input  logic                                    csr_wr_en,
   input  logic [rcpmq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rcpmq_pkg::CSR_BITS-1:0]          csr_wdata
);

   rcpmq_pkg::cfg_type                     cfg;
   rcpmq_pkg::ovr_res_type                 ovr_res;
   rcpmq_pkg::dir_cmd_type                 dir_cmd;
   logic                                   ovr_flag;

   logic                                   in_valid_ff;
   logic                                   in_type_ff;
   logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0] in_pulse_ff;
   logic                                   advance;
   logic                                   ovr_step;
   logic                                   dir_step;
   logic                                   speed_ok;

   logic                                   out_valid_ff;
   logic                                   out_active_ff;
   logic                                   out_active_in;
   logic                                   out_arm_robot_ff;
   logic                                   out_arm_motor_ff;
   logic                                   out_mvalid_ff;
   logic                                   out_mvalid_in;
   logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0] out_mpulse_ff;
   logic [rcpmq_pkg::PULSE_WIDTH_BITS-1:0] out_mpulse_in;
   logic [1:0]                             out_dcmd_ff;
   logic [1:0]                             out_dcmd_in;
   logic                                   is_ovr_chan;

   rcpmq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcpmq_ovr u_ovr (
      .clock       (clock),
      .reset       (reset),
      .step        (ovr_step),
      .pulse_width (in_pulse_ff),
      .cfg         (cfg),
      .flag        (ovr_flag),
      .res         (ovr_res)
   );

   rcpmq_dir u_dir (
      .clock       (clock),
      .reset       (reset),
      .step        (dir_step),
      .pulse_width (in_pulse_ff),
      .cfg         (cfg),
      .dir_cmd     (dir_cmd)
   );

   // advance the held pulse when the result register is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign is_ovr_chan = (in_type_ff == rcpmq_pkg::CHAN_OVERRIDE);
   assign ovr_step    = advance && is_ovr_chan;
   assign dir_step    = advance && !is_ovr_chan && !ovr_flag;

   always_comb begin
      speed_ok = (rcpmq_pkg::CMP_BITS'(in_pulse_ff) >= rcpmq_pkg::SPEED_MIN) &&
                 (rcpmq_pkg::CMP_BITS'(in_pulse_ff) <= rcpmq_pkg::SPEED_MAX);
      out_mvalid_in = 1'b0;
      out_mpulse_in = '0;
      out_dcmd_in   = rcpmq_pkg::DIR_NONE;
      if (is_ovr_chan) begin
         out_active_in = ovr_res.flag;
      end else begin
         out_active_in = ovr_flag;
         if (ovr_flag) begin
            // drop out-of-range speed pulses
            if (speed_ok) begin
               out_mvalid_in = 1'b1;
               out_mpulse_in = in_pulse_ff;
            end
         end else begin
            out_dcmd_in = dir_cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff  <= req_type;
         in_pulse_ff <= req_pulse_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_active_ff    <= out_active_in;
         out_arm_robot_ff <= is_ovr_chan & ovr_res.arm_robot;
         out_arm_motor_ff <= is_ovr_chan & ovr_res.arm_motor;
         out_mvalid_ff    <= out_mvalid_in;
         out_mpulse_ff    <= out_mpulse_in;
         out_dcmd_ff      <= out_dcmd_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_override_active   = out_active_ff;
   assign rsp_arm_robot         = out_arm_robot_ff;
   assign rsp_arm_motor         = out_arm_motor_ff;
   assign rsp_motor_pulse_valid = out_mvalid_ff;
   assign rsp_motor_pulse       = out_mpulse_ff;
   assign rsp_direction_cmd     = out_dcmd_ff;

   a_arm_motor_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arm_motor) |-> rsp_override_active)
      else $error("arm_motor without override active");

   a_arm_robot_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arm_robot) |-> !rsp_override_active)
      else $error("arm_robot with override still active");

   a_motor_only_in_override: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motor_pulse_valid) |->
         (rsp_override_active && rsp_direction_cmd == rcpmq_pkg::DIR_NONE))
      else $error("motor pulse forwarded outside override");

   a_step_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced pulse lost its result slot");

endmodule

@@ dv/rc_pulse_mode_qualifier_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_mode_qualifier_top_test: self-checking bench for the mode qualifier
// Walks a short table of hand-picked pulses, then runs phases of random
// pulse bursts under different settings. Each beat is compared against its
// typed expectation or a cycle-free model of the override counter, flag edges,
// motor forwarding and the direction run counter. Both sides stall at random.
// ----------------------------------------------------------------------------
module rc_pulse_mode_qualifier_top_test;
   import rcpmq_pkg::*;

   localparam int PW = PULSE_WIDTH_BITS;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 90;

   typedef struct packed {
      logic          override_active;
      logic          arm_robot;
      logic          arm_motor;
      logic          motor_pulse_valid;
      logic [PW-1:0] motor_pulse;
      dir_cmd_type   direction_cmd;
   } mode_result_t;

   typedef enum bit {ROW_PULSE, ROW_CSR} row_kind_t;

   typedef struct {
      row_kind_t                 kind;
      logic                      chan;
      logic [CSR_BITS-1:0]       value;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      bit                        typed;
      mode_result_t              want;
   } plan_row_t;

   typedef enum int {
      STYLE_RESET, STYLE_WIDE, STYLE_SHUT, STYLE_ZERO, STYLE_TIGHT, STYLE_TYPICAL, STYLE_WILD
   } mode_style_t;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_type;
   logic [PW-1:0]             req_pulse_width;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_override_active;
   logic                      rsp_arm_robot;
   logic                      rsp_arm_motor;
   logic                      rsp_motor_pulse_valid;
   logic [PW-1:0]             rsp_motor_pulse;
   logic [1:0]                rsp_direction_cmd;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]       csr_wdata;

   // typed expectation that rides along with the offered beat
   bit           beat_typed;
   mode_result_t beat_want;

   // model state
   cfg_type mode_cfg;
   int      ovr_count;
   bit      ovr_flag;
   int      dir_run;

   mode_result_t expected_q[$];
   plan_row_t    plan[$];
   int           error_count;
   int           quiet_cycles;
   int           rx_count;
   bit           calm_tx;
   bit           calm_rx;

   rc_pulse_mode_qualifier_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_pulse_width       (req_pulse_width),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_override_active   (rsp_override_active),
      .rsp_arm_robot         (rsp_arm_robot),
      .rsp_arm_motor         (rsp_arm_motor),
      .rsp_motor_pulse_valid (rsp_motor_pulse_valid),
      .rsp_motor_pulse       (rsp_motor_pulse),
      .rsp_direction_cmd     (rsp_direction_cmd),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the override count, flag and direction run by one pulse.
   function automatic mode_result_t qualify_pulse(logic chan, logic [PW-1:0] pw);
      mode_result_t r;
      bit was_on;
      int target;
      int lim;
      r = '0;
      r.direction_cmd = DIR_NONE;
      target = int'(mode_cfg.ovr_count_target);
      lim = int'(mode_cfg.dir_count_limit);
      if (chan == CHAN_OVERRIDE) begin
         was_on = ovr_flag;
         if (pw > mode_cfg.ovr_on_low && pw < mode_cfg.ovr_on_high) begin
            ovr_count++;
            if (ovr_count >= target) begin
               ovr_count = target;
               ovr_flag = 1'b1;
            end
         end else if (pw < mode_cfg.ovr_off_high && pw > mode_cfg.ovr_off_low) begin
            ovr_count--;
            if (ovr_count <= 0) begin
               ovr_count = 0;
               ovr_flag = 1'b0;
            end
         end
         r.arm_robot = was_on && !ovr_flag;
         r.arm_motor = ovr_flag && !was_on;
      end else if (ovr_flag) begin
         if (pw >= SPEED_MIN && pw <= SPEED_MAX) begin
            r.motor_pulse_valid = 1'b1;
            r.motor_pulse = pw;
         end
      end else begin
         if (pw < mode_cfg.dir_rev_below)
            dir_run--;
         else if (pw > mode_cfg.dir_fwd_above)
            dir_run++;
         else
            dir_run = 0;
         if (dir_run < -lim) begin
            dir_run = -lim;
            r.direction_cmd = DIR_REV;
         end else if (dir_run > lim) begin
            dir_run = lim;
            r.direction_cmd = DIR_FWD;
         end
      end
      r.override_active = ovr_flag;
      return r;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_BITS-1:0] v);
      case (idx)
         CSR_OVR_ON_LOW:       mode_cfg.ovr_on_low = v;
         CSR_OVR_ON_HIGH:      mode_cfg.ovr_on_high = v;
         CSR_OVR_OFF_LOW:      mode_cfg.ovr_off_low = v;
         CSR_OVR_OFF_HIGH:     mode_cfg.ovr_off_high = v;
         CSR_OVR_COUNT_TARGET: mode_cfg.ovr_count_target = v[COUNT_BITS-1:0];
         CSR_DIR_REV_BELOW:    mode_cfg.dir_rev_below = v;
         CSR_DIR_FWD_ABOVE:    mode_cfg.dir_fwd_above = v;
         CSR_DIR_COUNT_LIMIT:  mode_cfg.dir_count_limit = v[COUNT_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic string show(mode_result_t r);
      return $sformatf("act=%0b arm_r=%0b arm_m=%0b mvalid=%0b mpulse=%0d dir=%0d",
                       r.override_active, r.arm_robot, r.arm_motor, r.motor_pulse_valid,
                       r.motor_pulse, r.direction_cmd);
   endfunction

   function automatic int unsigned draw_gap(bit calm);
      return calm ? 0 : $urandom_range(19, 0);
   endfunction

   function automatic void row_pulse(logic chan, logic [PW-1:0] pw);
      plan_row_t r;
      r.kind = ROW_PULSE;
      r.chan = chan;
      r.value = pw;
      r.csr_idx = '0;
      r.typed = 1'b0;
      r.want = '0;
      plan.push_back(r);
   endfunction

   function automatic void row_typed(logic chan, logic [PW-1:0] pw, bit act, bit ar, bit am,
                                     bit mv, logic [PW-1:0] mp, dir_cmd_type dc);
      plan_row_t r;
      r.kind = ROW_PULSE;
      r.chan = chan;
      r.value = pw;
      r.csr_idx = '0;
      r.typed = 1'b1;
      r.want = '{act, ar, am, mv, mp, dc};
      plan.push_back(r);
   endfunction

   function automatic void row_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_BITS-1:0] v);
      plan_row_t r;
      r.kind = ROW_CSR;
      r.chan = CHAN_OVERRIDE;
      r.value = v;
      r.csr_idx = idx;
      r.typed = 1'b0;
      r.want = '0;
      plan.push_back(r);
   endfunction

   function automatic logic [PW-1:0] pick_between(logic [CSR_BITS-1:0] lo, logic [CSR_BITS-1:0] hi);
      int unsigned a;
      int unsigned b;
      a = 32'(lo);
      b = 32'(hi);
      if (b >= a + 2)
         return PW'($urandom_range(b - 1, a + 1));
      return PW'($urandom);
   endfunction

   // Random pulse in the class picked by cat, shaped by the live settings.
   function automatic logic [PW-1:0] shape_pulse(logic chan, int unsigned cat);
      logic [PW-1:0] edges[8];
      int unsigned rev;
      int unsigned fwd;
      rev = 32'(mode_cfg.dir_rev_below);
      fwd = 32'(mode_cfg.dir_fwd_above);
      if (chan == CHAN_OVERRIDE) begin
         edges = '{mode_cfg.ovr_on_low, mode_cfg.ovr_on_high, mode_cfg.ovr_off_low,
                   mode_cfg.ovr_off_high, mode_cfg.ovr_on_low + 16'd1,
                   mode_cfg.ovr_off_high - 16'd1, 16'd0, 16'hffff};
         if (cat < 45) return pick_between(mode_cfg.ovr_on_low, mode_cfg.ovr_on_high);
         if (cat < 80) return pick_between(mode_cfg.ovr_off_low, mode_cfg.ovr_off_high);
         if (cat < 90) return edges[3'($urandom_range(7, 0))];
         return PW'($urandom);
      end
      edges = '{16'd999, 16'd1000, 16'd2000, 16'd2001, mode_cfg.dir_rev_below,
                mode_cfg.dir_fwd_above, 16'd0, 16'hffff};
      if (cat < 25) return PW'($urandom_range(2000, 1000));
      if (cat < 45) return PW'((rev > 0) ? $urandom_range(rev - 1, 0) : $urandom);
      if (cat < 65) return PW'((fwd < 65535) ? $urandom_range(65535, fwd + 1) : $urandom);
      if (cat < 75) return PW'((fwd >= rev) ? $urandom_range(fwd, rev) : $urandom);
      if (cat < 85) return edges[3'($urandom_range(7, 0))];
      return PW'($urandom);
   endfunction

   function automatic cfg_type draw_mode(mode_style_t style);
      cfg_type m;
      int unsigned lo;
      lo = $urandom_range(1950, 1700);
      m.ovr_on_low = CSR_BITS'(lo);
      m.ovr_on_high = CSR_BITS'(lo + $urandom_range(300, 20));
      lo = $urandom_range(1000, 800);
      m.ovr_off_low = CSR_BITS'(lo);
      m.ovr_off_high = CSR_BITS'(lo + $urandom_range(400, 50));
      m.ovr_count_target = COUNT_BITS'($urandom_range(15, 1));
      m.dir_rev_below = CSR_BITS'($urandom_range(1400, 1000));
      m.dir_fwd_above = CSR_BITS'($urandom_range(2000, 1600));
      m.dir_count_limit = COUNT_BITS'($urandom_range(15, 1));
      case (style)
         STYLE_RESET: m = '{16'd1900, 16'd2010, 16'd900, 16'd1200, 4'd5, 16'd1200, 16'd1800, 4'd5};
         STYLE_WIDE:  m = '{16'd0, 16'hffff, 16'hffff, 16'd0, 4'd15, 16'hffff, 16'd0, 4'd15};
         STYLE_SHUT:  m = '{16'hffff, 16'd0, 16'd0, 16'hffff, 4'd1, 16'd0, 16'hffff, 4'd1};
         STYLE_ZERO:  m = '{16'd1900, 16'd2010, 16'd900, 16'd1200, 4'd0, 16'd1200, 16'd1800, 4'd0};
         STYLE_TIGHT: begin
            m.ovr_count_target = COUNT_BITS'($urandom_range(4, 2));
            m.dir_count_limit = COUNT_BITS'($urandom_range(3, 1));
         end
         STYLE_WILD: begin
            m.ovr_on_low = CSR_BITS'($urandom);
            m.ovr_on_high = CSR_BITS'($urandom);
            m.ovr_off_low = CSR_BITS'($urandom);
            m.ovr_off_high = CSR_BITS'($urandom);
            m.ovr_count_target = COUNT_BITS'($urandom);
            m.dir_rev_below = CSR_BITS'($urandom);
            m.dir_fwd_above = CSR_BITS'($urandom);
            m.dir_count_limit = COUNT_BITS'($urandom);
         end
         default: ;
      endcase
      return m;
   endfunction

   // Offer one pulse beat and hold it until the block takes it.
   task automatic offer_pulse(input logic chan, input logic [PW-1:0] pw, input bit typed,
                              input mode_result_t want);
      int unsigned gap;
      gap = draw_gap(calm_tx);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= chan;
      req_pulse_width <= pw;
      beat_typed <= typed;
      beat_want <= want;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(39, 0) == 0) calm_tx = !calm_tx;
   endtask

   // Drop valid and wait until every result is back and the pipe is empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CSR_BITS-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      apply_csr(idx, v);
   endtask

   task automatic load_mode(input cfg_type m);
      logic [CSR_BITS-1:0] junk;
      settle();
      // upper bits of the narrow registers carry noise half the time
      junk = $urandom_range(1, 0) ? CSR_BITS'($urandom) : '0;
      write_reg(CSR_OVR_ON_LOW, m.ovr_on_low);
      write_reg(CSR_OVR_ON_HIGH, m.ovr_on_high);
      write_reg(CSR_OVR_OFF_LOW, m.ovr_off_low);
      write_reg(CSR_OVR_OFF_HIGH, m.ovr_off_high);
      write_reg(CSR_OVR_COUNT_TARGET, {junk[CSR_BITS-1:COUNT_BITS], m.ovr_count_target});
      write_reg(CSR_DIR_REV_BELOW, m.dir_rev_below);
      write_reg(CSR_DIR_FWD_ABOVE, m.dir_fwd_above);
      write_reg(CSR_DIR_COUNT_LIMIT, {junk[CSR_BITS-1:COUNT_BITS], m.dir_count_limit});
      csr_wr_en <= 1'b0;
   endtask

   // Predict on every accepted pulse, check on every accepted result.
   always @(posedge clock) begin
      mode_result_t pred;
      mode_result_t got;
      mode_result_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pred = qualify_pulse(req_type, req_pulse_width);
            expected_q.push_back(beat_typed ? beat_want : pred);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_override_active, rsp_arm_robot, rsp_arm_motor, rsp_motor_pulse_valid,
                    rsp_motor_pulse, dir_cmd_type'(rsp_direction_cmd)};
            if (expected_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("result beat with no pulse pending: %s", show(got));
            end else begin
               want = expected_q.pop_front();
               if (got.override_active !== want.override_active ||
                   got.arm_robot !== want.arm_robot ||
                   got.arm_motor !== want.arm_motor ||
                   got.motor_pulse_valid !== want.motor_pulse_valid ||
                   got.motor_pulse !== want.motor_pulse ||
                   got.direction_cmd !== want.direction_cmd) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch at %0t: expected %s, got %s", $realtime, show(want),
                              show(got));
               end
            end
         end
      end
   end

   // Watchdog: any accepted beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("stalled for %0d cycles, %0d results outstanding", QUIET_LIMIT,
                  expected_q.size());
         $display("rc_pulse_mode_qualifier_top_test: done, errors");
         $finish;
      end
   end

   // Result side: random stalls, plus two long hold-offs to back up the pipe.
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap(calm_rx);
         if (rx_count == 400 || rx_count == 1300)
            stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rx_count++;
         if ($urandom_range(39, 0) == 0) calm_rx = !calm_rx;
      end
   end

   initial begin
      mode_style_t phase_plan[$];
      logic        chan;
      int unsigned cat;
      int unsigned burst;
      int          sent;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= CHAN_OVERRIDE;
      req_pulse_width <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_OVR_ON_LOW;
      csr_wdata <= '0;
      beat_typed <= 1'b0;
      beat_want <= '0;
      mode_cfg = draw_mode(STYLE_RESET);
      ovr_count = 0;
      ovr_flag = 1'b0;
      dir_run = 0;
      error_count = 0;
      quiet_cycles = 0;
      rx_count = 0;
      calm_tx = 1'b0;
      calm_rx = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, starting from the reset settings.
      row_typed(CHAN_OVERRIDE, 16'd0,     0, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_OVERRIDE, 16'hffff,  0, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd0,     0, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_SPEED,    16'hffff,  0, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd1500,  0, 0, 0, 0, 16'd0, DIR_NONE);
      row_pulse(CHAN_OVERRIDE, 16'd1901);
      row_pulse(CHAN_OVERRIDE, 16'd1950);
      row_pulse(CHAN_OVERRIDE, 16'd2000);
      row_pulse(CHAN_OVERRIDE, 16'd2009);
      // count now sits above the lowered target: next up-count clamps and sets
      row_csr(CSR_OVR_COUNT_TARGET, 16'd2);
      row_typed(CHAN_OVERRIDE, 16'd1950,  1, 0, 1, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd1000,  1, 0, 0, 1, 16'd1000, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd2000,  1, 0, 0, 1, 16'd2000, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd999,   1, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd2001,  1, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_OVERRIDE, 16'd2010,  1, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_OVERRIDE, 16'd1900,  1, 0, 0, 0, 16'd0, DIR_NONE);
      row_pulse(CHAN_OVERRIDE, 16'd1199);
      row_typed(CHAN_OVERRIDE, 16'd901,   0, 1, 0, 0, 16'd0, DIR_NONE);
      row_csr(CSR_DIR_COUNT_LIMIT, 16'd0);
      row_typed(CHAN_SPEED,    16'd1199,  0, 0, 0, 0, 16'd0, DIR_REV);
      row_typed(CHAN_SPEED,    16'd1200,  0, 0, 0, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_SPEED,    16'd1801,  0, 0, 0, 0, 16'd0, DIR_FWD);
      row_typed(CHAN_SPEED,    16'hffff,  0, 0, 0, 0, 16'd0, DIR_FWD);
      row_csr(CSR_OVR_COUNT_TARGET, 16'd0);
      row_typed(CHAN_OVERRIDE, 16'd1950,  1, 0, 1, 0, 16'd0, DIR_NONE);
      row_typed(CHAN_OVERRIDE, 16'd1000,  0, 1, 0, 0, 16'd0, DIR_NONE);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan[i].csr_idx, plan[i].value);
            csr_wr_en <= 1'b0;
         end else begin
            offer_pulse(plan[i].chan, plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      // Random phases: bursts of one pulse class so counters run deep.
      phase_plan = '{STYLE_RESET, STYLE_WIDE, STYLE_TIGHT, STYLE_TYPICAL,
                     STYLE_ZERO, STYLE_SHUT, STYLE_WILD, STYLE_TYPICAL};
      foreach (phase_plan[p]) begin
         load_mode(draw_mode(phase_plan[p]));
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            chan = ($urandom_range(9, 0) < 4) ? CHAN_OVERRIDE : CHAN_SPEED;
            cat = $urandom_range(99, 0);
            burst = $urandom_range(12, 1);
            for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               offer_pulse(chan, shape_pulse(chan, cat), 1'b0, '0);
               sent++;
            end
         end
      end

      settle();
      if (error_count == 0)
         $display("rc_pulse_mode_qualifier_top_test: done, clean");
      else
         $display("rc_pulse_mode_qualifier_top_test: done, errors");
      $finish;
   end

endmodule
